// ===== hw/rtl/first_duplicate_detector_top_macros.svh =====
// Assertion macros for the first duplicate detector.
// Used by first_duplicate_detector_top.sv; no other dependencies.
`ifndef FIRST_DUPLICATE_DETECTOR_TOP_MACROS_SVH
`define FIRST_DUPLICATE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define FDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the first duplicate detector.
// No dependencies; imported by every module of the block but fdd_ram.
package fdd_pkg;

	// Input word: one number of the sequence
	typedef struct packed {
		logic signed [31:0] value;
		logic               is_last;
	} fdd_in_t;

	// Result word: one per sequence
	typedef struct packed {
		logic               found;
		logic signed [31:0] first_repeat;
		logic               overflow;
	} fdd_out_t;

	// Multiplicative hash constant (golden ratio)
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	// Table generation tag width
	localparam int EPOCH_W = 8;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Queue status seen by front and back
	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] fill;
	} fdd_qstat_t;

endpackage

// ===== hw/rtl/fdd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdd_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/fdd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, hashes the value and pushes it to the queue.
// Depends on fdd_pkg.
module fdd_front #(
	parameter int IW = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fdd_pkg::fdd_in_t    item,
	input  fdd_pkg::fdd_qstat_t qstat,
	input  logic                clearing,
	output logic                busy,
	output logic                push,
	output fdd_pkg::fdd_in_t    push_item,
	output logic [IW-1:0]       push_hash
);
	import fdd_pkg::*;

	logic             valid_s1;
	fdd_in_t          item_s1;
	logic [IW-1:0]    hash_s1;
	logic [31:0]      prod;
	logic [QCNT_W:0]  load;
	logic             accept;

	// hold off while the queue cannot take this word plus the one in flight
	assign load   = (QCNT_W + 1)'(qstat.fill) + (QCNT_W + 1)'(valid_s1);
	assign busy   = clearing || (load >= (QCNT_W + 1)'(QUEUE_DEPTH));
	assign accept = start && !busy;

	// hash: top bits of the low product word
	assign prod = item.value * HASH_MULT;

	// advance the hash stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			hash_s1 <= prod[31 -: IW];
		end
	end

	assign push      = valid_s1;
	assign push_item = item_s1;
	assign push_hash = hash_s1;

endmodule

// ===== hw/rtl/fdd_fifo.sv =====
`timescale 1ns / 1ps
// Short queue between the hashing front end and the table back end.
// Depends on fdd_pkg.
module fdd_fifo #(
	parameter int W = 44
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        wdata,
	input  logic                pop,
	output logic [W-1:0]        head,
	output fdd_pkg::fdd_qstat_t qstat
);
	import fdd_pkg::*;

	logic [W-1:0]      mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.fill  = fill_q;
	assign qstat.empty = (fill_q == '0);

endmodule

// ===== hw/rtl/fdd_back.sv =====
`timescale 1ns / 1ps
// Back end: probes the open-addressing hash table, inserts new values,
// tracks the first repeat and emits the result word. Depends on fdd_pkg, fdd_ram.
module fdd_back #(
	parameter int SET_ENTRIES = 1024,
	parameter int IW          = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fdd_pkg::fdd_qstat_t qstat,
	input  fdd_pkg::fdd_in_t    head_item,
	input  logic [IW-1:0]       head_hash,
	output logic                pop,
	output logic                clearing,
	output logic                result_valid,
	output fdd_pkg::fdd_out_t   result
);
	import fdd_pkg::*;

	localparam int TBL_DEPTH = 2 ** IW;
	localparam int TW        = EPOCH_W + 32;
	localparam int CW        = $clog2(SET_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      clr_idx_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [31:0]        val_q;
	logic               last_q;
	logic [IW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic               found_q;
	logic [31:0]        rep_q;
	logic               ovf_q;
	logic               res_valid_q;
	fdd_out_t           res_q;

	logic               we;
	logic [IW-1:0]      waddr;
	logic [TW-1:0]      wdata;
	logic [IW-1:0]      raddr;
	logic [TW-1:0]      rd_word;
	logic               occupied;
	logic               hit;
	logic               done;
	logic               done_last;
	logic               found_d;
	logic [31:0]        rep_d;
	logic               ovf_d;
	logic [CW-1:0]      cnt_d;
	logic [EPOCH_W-1:0] epoch_nxt;
	logic               wrap;

	fdd_ram #(
		.WIDTH(TW),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_word)
	);

	// a slot is live only when tagged with the current generation
	assign occupied  = (rd_word[TW-1 -: EPOCH_W] == epoch_q);
	assign hit       = occupied && (rd_word[31:0] == val_q);
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;
	assign clearing  = (state_q == ST_CLEAR);
	assign epoch_nxt = epoch_q + 1'b1;
	assign wrap      = (epoch_nxt == '0);

	// classify the probe, decide insert and flag updates
	always_comb begin
		found_d   = found_q;
		rep_d     = rep_q;
		ovf_d     = ovf_q;
		cnt_d     = count_q;
		done      = 1'b0;
		done_last = 1'b0;
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = {epoch_q, val_q};
		raddr     = head_hash;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_idx_q;
				wdata = '0;
			end
			ST_IDLE: begin
				// after a repeat, drop words without a lookup
				if (!qstat.empty && found_q) begin
					done      = 1'b1;
					done_last = head_item.is_last;
				end
			end
			ST_PROBE: begin
				raddr = idx_q + 1'b1;
				if (hit) begin
					found_d   = 1'b1;
					rep_d     = val_q;
					done      = 1'b1;
					done_last = last_q;
				end else if (!occupied) begin
					if (count_q < CW'(SET_ENTRIES)) begin
						we    = 1'b1;
						cnt_d = count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					done      = 1'b1;
					done_last = last_q;
				end
			end
			default: begin
			end
		endcase
	end

	// hold state, flags and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			epoch_q     <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			rep_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= done_last;
			if (done_last) begin
				// end of sequence: drop the set by moving to a new generation
				count_q <= '0;
				found_q <= 1'b0;
				rep_q   <= '0;
				ovf_q   <= 1'b0;
				epoch_q <= epoch_nxt;
				state_q <= wrap ? ST_CLEAR : ST_IDLE;
			end else begin
				count_q <= cnt_d;
				found_q <= found_d;
				rep_q   <= rep_d;
				ovf_q   <= ovf_d;
				unique case (state_q)
					ST_CLEAR: begin
						clr_idx_q <= clr_idx_q + 1'b1;
						if (clr_idx_q == IW'(TBL_DEPTH - 1)) begin
							state_q <= ST_IDLE;
							epoch_q <= EPOCH_W'(1);
						end
					end
					ST_IDLE: begin
						if (pop && !found_q) begin
							state_q <= ST_PROBE;
						end
					end
					ST_PROBE: begin
						if (done) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_CLEAR;
					end
				endcase
			end
		end
	end

	// load the word under test, step the probe index and capture the result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			val_q  <= head_item.value;
			last_q <= head_item.is_last;
			idx_q  <= head_hash;
		end else if (state_q == ST_PROBE && !done) begin
			idx_q <= idx_q + 1'b1;
		end
		if (done_last) begin
			res_q.found        <= found_d;
			res_q.first_repeat <= found_d ? rep_d : '0;
			res_q.overflow     <= ovf_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/first_duplicate_detector_top.sv =====
`timescale 1ns / 1ps
// First duplicate detector: a value is written each time start is high and busy is low; the
// word with is_last set ends the sequence; after it passes the hash stage, queue and probe,
// one result word appears for exactly one cycle with result_valid high and must be taken
// then. The result gives the earliest value seen twice (found) and whether the set ran out
// of room (overflow). Values go through a registered hash stage and a four-word queue into
// a back end that probes an open-addressing table of 2*SET_ENTRIES (rounded up to a power
// of two) entries held in one RAM. A word is dequeued, then slots are probed in turn until
// a hit or a free slot before the next word is taken; once a repeat is found, each further
// word of the sequence is dropped without a lookup. After reset, and after every 255th
// sequence, the table is swept clean at one entry per cycle while busy stays high.
// Depends on fdd_pkg, fdd_front, fdd_fifo, fdd_back, fdd_ram and the macros header.
`include "first_duplicate_detector_top_macros.svh"

module first_duplicate_detector_top #(
	parameter int SET_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fdd_pkg::fdd_in_t  item,
	output logic              busy,
	output logic              result_valid,
	output fdd_pkg::fdd_out_t result
);
	import fdd_pkg::*;

	localparam int IW = $clog2(SET_ENTRIES) + 1;
	localparam int IT = $bits(fdd_in_t);
	localparam int QW = IW + IT;

	fdd_qstat_t    qstat;
	logic          q_push;
	fdd_in_t       push_item;
	logic [IW-1:0] push_hash;
	logic          q_pop;
	logic [QW-1:0] q_head;
	fdd_in_t       head_item;
	logic [IW-1:0] head_hash;
	logic          clearing;

	// accept and hash
	fdd_front #(
		.IW(IW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.qstat    (qstat),
		.clearing (clearing),
		.busy     (busy),
		.push     (q_push),
		.push_item(push_item),
		.push_hash(push_hash)
	);

	// decouple front and back
	fdd_fifo #(
		.W(QW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({push_hash, push_item}),
		.pop   (q_pop),
		.head  (q_head),
		.qstat (qstat)
	);

	assign head_item = fdd_in_t'(q_head[IT-1:0]);
	assign head_hash = q_head[QW-1 -: IW];

	// probe, insert and report
	fdd_back #(
		.SET_ENTRIES(SET_ENTRIES),
		.IW         (IW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head_item   (head_item),
		.head_hash   (head_hash),
		.pop         (q_pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result      (result)
	);

	// checks
	`FDD_ASSERT_NOW(a_no_repeat_zero, clk, arst_n, result_valid && !result.found, result.first_repeat == 0, "first_repeat nonzero without a repeat")
	`FDD_ASSERT_NEXT(a_result_gap, clk, arst_n, result_valid, !result_valid, "result words back to back")
	`FDD_ASSERT_NOW(a_clear_busy, clk, arst_n, clearing, busy, "word accepted during table sweep")
	`FDD_ASSERT_NOW(a_queue_room, clk, arst_n, q_push && !q_pop, qstat.fill != QCNT_W'(QUEUE_DEPTH), "push into a full queue")

endmodule

// ===== tb/tb_first_duplicate_detector_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_duplicate_detector_top: directed word table, then random
// sequences, checked against hand-written rows or an in-bench repeat-tracking predictor.
// Depends on fdd_pkg and the first_duplicate_detector_top RTL.
module tb_first_duplicate_detector_top;
	import fdd_pkg::*;

	localparam int          SET_ENTRIES = 1024;
	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam logic [31:0] INT_MIN     = 32'h8000_0000;
	localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	// One directed row: the word, and a hand-written result where it is obvious
	typedef struct packed {
		logic [31:0] value;
		logic        is_last;
		logic        typed;
		logic        found;
		logic [31:0] first_repeat;
		logic        overflow;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// single-word sequences at the extremes
		'{INT_MIN, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
		'{INT_MAX, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
		// zero repeats: found with a zero value
		'{32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{ALL_ONES, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h0, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0},
		// -1 repeats first, later repeat of 5 is ignored
		'{ALL_ONES, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd5, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{ALL_ONES, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd5, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd7, 1'b1, 1'b1, 1'b1, ALL_ONES, 1'b0},
		// repeat lands on the final word
		'{INT_MIN, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{INT_MAX, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{INT_MAX, 1'b1, 1'b1, 1'b1, INT_MAX, 1'b0},
		// no repeat at all
		'{32'd1, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd2, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd3, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd4, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
		// back-to-back repeat, words after it ignored
		'{32'd9, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd9, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd10, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'd10, 1'b1, 1'b1, 1'b1, 32'd9, 1'b0},
		// alternating bit patterns
		'{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
		'{32'h5555_5555, 1'b1, 1'b1, 1'b1, 32'h5555_5555, 1'b0}
	};

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	fdd_in_t  item   = '0;
	logic     busy;
	logic     result_valid;
	fdd_out_t result;

	// Predictor state: values seen in the current sequence and its flags
	bit          seen_set [logic [31:0]];
	bit          rep_hit;
	logic [31:0] rep_val;
	bit          set_full_hit;

	fdd_out_t    pending_results [$];
	fdd_out_t    want;
	int unsigned cycle_cnt;
	int unsigned mismatch_cnt;
	int unsigned words_sent;
	int unsigned seq_cnt;
	int unsigned results_seen;
	int unsigned found_cnt;
	int unsigned ovf_cnt;

	first_duplicate_detector_top #(
		.SET_ENTRIES(SET_ENTRIES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);

	// Free-running 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		mismatch_cnt++;
		$display("[%0t] mismatch: %s got %0h want %0h", $realtime, what, got, exp_val);
	endtask

	// Track one word through the current sequence; return 1 and the result on the final word
	function automatic bit detect_repeat(input fdd_in_t w, output fdd_out_t r);
		logic [31:0] key;
		key = w.value;
		r = '0;
		if (!rep_hit) begin
			if (seen_set.exists(key)) begin
				rep_hit = 1'b1;
				rep_val = key;
			end else if (seen_set.num() >= SET_ENTRIES) begin
				set_full_hit = 1'b1;
			end else begin
				seen_set[key] = 1'b1;
			end
		end
		if (!w.is_last)
			return 1'b0;
		r.found        = rep_hit;
		r.first_repeat = rep_hit ? rep_val : 32'h0;
		r.overflow     = set_full_hit;
		seen_set.delete();
		rep_hit      = 1'b0;
		rep_val      = '0;
		set_full_hit = 1'b0;
		return 1'b1;
	endfunction

	// Hold the word until it is taken, then predict
	task automatic send_word(input fdd_in_t w, input bit typed_on, input fdd_out_t typed);
		fdd_out_t r;
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
		if (detect_repeat(w, r)) begin
			pending_results.push_back(typed_on ? typed : r);
			seq_cnt++;
		end
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drive one random sequence; the style decides how likely a repeat is
	task automatic run_sequence(input int len, input bit idle_on);
		logic [31:0] hist [$];
		logic [31:0] base;
		logic [31:0] v;
		fdd_in_t     w;
		int          style;
		style = $urandom_range(0, 3);
		base  = $urandom;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: v = base + $urandom_range(0, len);
				1: v = $urandom;
				2: v = (i > 0 && $urandom_range(0, 3) == 0) ?
					hist[$urandom_range(0, i - 1)] : $urandom;
				default: begin
					case ($urandom_range(0, 4))
						0: v = INT_MIN;
						1: v = INT_MAX;
						2: v = 32'h0;
						3: v = ALL_ONES;
						default: v = base;
					endcase
				end
			endcase
			hist.push_back(v);
			w.value   = v;
			w.is_last = (i == len - 1);
			send_word(w, 1'b0, '0);
			if (idle_on && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 8));
		end
	endtask

	// Run random sequences until both the word and sequence counts are reached
	task automatic run_random(input int unsigned word_goal, input int unsigned seq_goal,
			input bit idle_ok);
		int len;
		while (words_sent < word_goal || seq_cnt < seq_goal) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: len = 1;
				9, 10, 11, 12, 13:         len = $urandom_range(2, 4);
				14, 15, 16, 17:            len = $urandom_range(5, 12);
				default:                   len = $urandom_range(13, 40);
			endcase
			run_sequence(len, idle_ok && $urandom_range(0, 9) < 7);
		end
	endtask

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending", result.first_repeat, '0);
			end else begin
				want = pending_results.pop_front();
				if (result.found !== want.found)
					report_mismatch("found", result.found, want.found);
				if (result.first_repeat !== want.first_repeat)
					report_mismatch("first_repeat", result.first_repeat, want.first_repeat);
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", result.overflow, want.overflow);
				if (want.found)
					found_cnt++;
				if (want.overflow)
					ovf_cnt++;
			end
		end
	end

	initial begin
		fdd_in_t     w;
		fdd_out_t    typed;

		// Hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int k = 0; k < DIR_ROWS; k++) begin
			w.value            = DIR_TAB[k].value;
			w.is_last          = DIR_TAB[k].is_last;
			typed.found        = DIR_TAB[k].found;
			typed.first_repeat = DIR_TAB[k].first_repeat;
			typed.overflow     = DIR_TAB[k].overflow;
			send_word(w, DIR_TAB[k].typed, typed);
		end

		// Random sequences with sender idling
		run_random(520, 60, 1'b1);

		// Drain before the last stretch
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);

		// Last stretch runs without idling
		run_random(words_sent + 330, 0, 1'b0);
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d words in %0d sequences; checked %0d result words.",
			words_sent, seq_cnt, results_seen);
		$display("Results with a repeat: %0d, with set overflow: %0d.", found_cnt, ovf_cnt);
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fdd_pkg.sv
hw/rtl/fdd_ram.sv
hw/rtl/fdd_front.sv
hw/rtl/fdd_fifo.sv
hw/rtl/fdd_back.sv
hw/rtl/first_duplicate_detector_top.sv
tb/tb_first_duplicate_detector_top.sv
